[rtl/qos_vote_max_aggregator_core_defines.svh]
// ----------------------------------------------------------------------------
// QoS vote aggregator assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef QOS_VOTE_MAX_AGGREGATOR_CORE_DEFINES_SVH
`define QOS_VOTE_MAX_AGGREGATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define QVA_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define QVA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/qva_pkg.sv]
// ----------------------------------------------------------------------------
// QoS vote aggregator package
// Sizes, operation and status codes and the result layout.
// ----------------------------------------------------------------------------
package qva_pkg;

    localparam int VOTE_SLOTS  = 16;
    localparam int NUM_CLASSES = 6;
    localparam int DEPTH       = VOTE_SLOTS * NUM_CLASSES;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W      = (VOTE_SLOTS > 1) ? $clog2(VOTE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(VOTE_SLOTS + 1);
    localparam int CLS_IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 72;

    localparam logic [31:0] DEFAULT_VOTE_ID = 32'hAB0C_DEFA;

    typedef enum logic [2:0] {
        OP_REQUEST     = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_GET_TARGET  = 3'd2,
        OP_GET_VOTE    = 3'd3,
        OP_VOTE_ACTIVE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_CLASS = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic        power_down;
        logic        power_up;
        logic        target_changed;
        logic        vote_active;
        logic [31:0] vote_value;
        logic [31:0] class_target;
        status_t     status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[rtl/qva_ram.sv]
// ----------------------------------------------------------------------------
// QoS vote aggregator RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/qos_vote_max_aggregator_core.sv]
// ----------------------------------------------------------------------------
// QoS vote max aggregator core
// Per-class vote tables with maximum-vote target and applied-value tracking.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request per item: s_tuser holds the operation
//   and the class, s_tdata the requester id and the requested value. The m_
//   channel returns exactly one result per request.
//   One request is in work at a time. A vote request takes two passes over
//   the class's slots (search, write back, target scan). A clear writes zero
//   to each slot, one per cycle, then scans. Target and vote queries take one
//   pass; an invalid class goes straight to its result. Each pass reads one
//   slot per cycle through the RAM ports.
//   The result sits in an output register; a new request is taken while it
//   waits, and its result is held back until the register is free.
//   Reset (aresetn low, synchronous) empties every table and zeroes the
//   applied values at once through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module qos_vote_max_aggregator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // requester_id, request_value
    input  logic [qva_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation, perf_class
    input  logic [qva_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, class_target, vote_value, vote_active, target_changed,
    // power_up, power_down, zero fill
    output logic [qva_pkg::M_TDATA_W-1:0]  m_tdata
);

    import qva_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLR   = 6'b000010,
        ST_SCAN1 = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_SCAN2 = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [2:0]          cls_reg, cls_next;
    logic [31:0]         key_reg, key_next;
    logic [31:0]         val_reg, val_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   proc_slot_reg, proc_slot_next;
    logic                id_vld_q_reg, id_vld_q_next;
    logic                val_vld_q_reg, val_vld_q_next;
    logic                match_found_reg, match_found_next;
    logic [SLOT_W-1:0]   match_slot_reg, match_slot_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;
    logic                stop_reg, stop_next;
    logic [31:0]         max_reg, max_next;
    logic [31:0]         qval_reg, qval_next;
    logic                full_reg, full_next;
    logic [DEPTH-1:0]    id_valid_reg, id_valid_next;
    logic [DEPTH-1:0]    val_valid_reg, val_valid_next;
    logic [31:0]         applied_reg [NUM_CLASSES];
    logic [31:0]         applied_next [NUM_CLASSES];
    result_t             out_reg, out_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                id_we;
    logic                val_we;
    logic [31:0]         val_wdata;
    logic [31:0]         id_rdata;
    logic [31:0]         val_rdata;
    logic [31:0]         cur_id;
    logic [31:0]         cur_val;
    logic [2:0]          in_op;
    logic [2:0]          in_cls;
    logic [31:0]         in_id;
    logic [31:0]         in_val;
    logic                scan_end;
    logic                bad_cls;
    logic                modify;
    logic                is_query;
    logic [31:0]         old_val;
    logic                changed;
    logic [CLS_IDX_W-1:0] cls_idx;

    assign in_op  = s_tuser[2:0];
    assign in_cls = s_tuser[5:3];
    assign in_id  = s_tdata[31:0];
    assign in_val = s_tdata[63:32];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    assign rd_addr   = base_reg + ADDR_W'(iss_cnt_reg[SLOT_W-1:0]);
    assign wr_addr   = (state_reg == ST_CLR) ? rd_addr :
                       base_reg + ADDR_W'(match_found_reg ? match_slot_reg : free_slot_reg);
    assign val_wdata = (state_reg == ST_CLR) ? 32'd0 : val_reg;
    assign cur_id    = id_vld_q_reg ? id_rdata : 32'd0;
    assign cur_val   = val_vld_q_reg ? val_rdata : 32'd0;

    assign scan_end = (iss_cnt_reg == CNT_W'(VOTE_SLOTS)) && !pend_reg;
    assign bad_cls  = int'(cls_reg) >= NUM_CLASSES;
    assign modify   = (op_reg == OP_REQUEST) || (op_reg == OP_CLEAR);
    assign is_query = (op_reg == OP_GET_VOTE) || (op_reg == OP_VOTE_ACTIVE);
    assign cls_idx  = cls_reg[CLS_IDX_W-1:0];
    assign old_val  = bad_cls ? 32'd0 : applied_reg[cls_idx];
    assign changed  = modify && (old_val != max_reg);

    qva_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_id_ram (
        .aclk  (aclk),
        .we    (id_we),
        .waddr (wr_addr),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (id_rdata)
    );

    qva_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        cls_next         = cls_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        base_next        = base_reg;
        iss_cnt_next     = iss_cnt_reg;
        pend_next        = 1'b0;
        proc_slot_next   = proc_slot_reg;
        id_vld_q_next    = id_vld_q_reg;
        val_vld_q_next   = val_vld_q_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        stop_next        = stop_reg;
        max_next         = max_reg;
        qval_next        = qval_reg;
        full_next        = full_reg;
        id_valid_next    = id_valid_reg;
        val_valid_next   = val_valid_reg;
        applied_next     = applied_reg;
        out_next         = out_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        id_we            = 1'b0;
        val_we           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next          = in_op;
                    cls_next         = in_cls;
                    key_next         = ((in_op == OP_REQUEST) && (in_id == 32'd0)) ?
                                       DEFAULT_VOTE_ID : in_id;
                    val_next         = in_val;
                    base_next        = ADDR_W'(int'(in_cls) * VOTE_SLOTS);
                    iss_cnt_next     = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    stop_next        = 1'b0;
                    max_next         = 32'd0;
                    qval_next        = 32'd0;
                    full_next        = 1'b0;
                    if (int'(in_cls) >= NUM_CLASSES) begin
                        state_next = ST_DONE;
                    end else if (in_op == OP_REQUEST) begin
                        state_next = ST_SCAN1;
                    end else if (in_op == OP_CLEAR) begin
                        state_next = ST_CLR;
                    end else begin
                        state_next = ST_SCAN2;
                    end
                end
            end
            ST_CLR: begin
                val_we                  = 1'b1;
                val_valid_next[wr_addr] = 1'b1;
                if (iss_cnt_reg == CNT_W'(VOTE_SLOTS - 1)) begin
                    iss_cnt_next = '0;
                    state_next   = ST_SCAN2;
                end else begin
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
            end
            ST_SCAN1, ST_SCAN2: begin
                if (iss_cnt_reg != CNT_W'(VOTE_SLOTS)) begin
                    iss_cnt_next   = iss_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    proc_slot_next = iss_cnt_reg[SLOT_W-1:0];
                    id_vld_q_next  = id_valid_reg[rd_addr];
                    val_vld_q_next = val_valid_reg[rd_addr];
                end
                if (pend_reg) begin
                    if (!match_found_reg && (cur_id == key_reg)) begin
                        match_found_next = 1'b1;
                        match_slot_next  = proc_slot_reg;
                        qval_next        = cur_val;
                    end
                    if (state_reg == ST_SCAN1) begin
                        if (!free_found_reg && (cur_id == 32'd0)) begin
                            free_found_next = 1'b1;
                            free_slot_next  = proc_slot_reg;
                        end
                    end else if (!stop_reg) begin
                        if (cur_id == 32'd0) begin
                            stop_next = 1'b1;
                        end else if (cur_val > max_reg) begin
                            max_next = cur_val;
                        end
                    end
                end
                if (scan_end) begin
                    state_next = (state_reg == ST_SCAN1) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                if (match_found_reg) begin
                    val_we = 1'b1;
                    val_valid_next[wr_addr] = 1'b1;
                end else if (free_found_reg) begin
                    id_we  = 1'b1;
                    val_we = 1'b1;
                    id_valid_next[wr_addr]  = 1'b1;
                    val_valid_next[wr_addr] = 1'b1;
                end else begin
                    full_next = 1'b1;
                end
                iss_cnt_next     = '0;
                match_found_next = 1'b0;
                stop_next        = 1'b0;
                max_next         = 32'd0;
                qval_next        = 32'd0;
                state_next       = ST_SCAN2;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_next      = '0;
                    if (bad_cls) begin
                        out_next.status = STATUS_BAD_CLASS;
                    end else begin
                        out_next.status         = full_reg ? STATUS_FULL : STATUS_OK;
                        out_next.class_target   = max_reg;
                        out_next.target_changed = changed;
                        if (changed) begin
                            applied_next[cls_idx] = max_reg;
                            if (cls_reg == 3'd0) begin
                                out_next.power_up   = (old_val == 32'd0);
                                out_next.power_down = (old_val != 32'd0) && (max_reg == 32'd0);
                            end
                        end
                        if (is_query) begin
                            out_next.vote_value  = qval_reg;
                            out_next.vote_active = (qval_reg != 32'd0);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            id_valid_reg  <= '0;
            val_valid_reg <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                applied_reg[c] <= 32'd0;
            end
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            id_valid_reg  <= id_valid_next;
            val_valid_reg <= val_valid_next;
            applied_reg   <= applied_next;
        end
        op_reg          <= op_next;
        cls_reg         <= cls_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        base_reg        <= base_next;
        iss_cnt_reg     <= iss_cnt_next;
        proc_slot_reg   <= proc_slot_next;
        id_vld_q_reg    <= id_vld_q_next;
        val_vld_q_reg   <= val_vld_q_next;
        match_found_reg <= match_found_next;
        match_slot_reg  <= match_slot_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        stop_reg        <= stop_next;
        max_reg         <= max_next;
        qval_reg        <= qval_next;
        full_reg        <= full_next;
        out_reg         <= out_next;
    end

endmodule

[rtl/qva_checker.sv]
// ----------------------------------------------------------------------------
// QoS vote aggregator checker
// Port-level assertions on the aggregator core, attached by bind.
// ----------------------------------------------------------------------------
`include "qos_vote_max_aggregator_core_defines.svh"

module qva_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [qva_pkg::M_TDATA_W-1:0] m_tdata
);

    import qva_pkg::*;

    `QVA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `QVA_ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `QVA_ASSERT_IMPLIES(a_bad_class_zero, aclk, aresetn, m_tvalid && (m_tdata[1:0] == STATUS_BAD_CLASS), m_tdata[69:2] == '0)
    `QVA_ASSERT_IMPLIES(a_power_event, aclk, aresetn, m_tvalid && (m_tdata[68] || m_tdata[69]), m_tdata[67] && !(m_tdata[68] && m_tdata[69]))
    `QVA_ASSERT_IMPLIES(a_active_value, aclk, aresetn, m_tvalid, m_tdata[66] == (m_tdata[65:34] != 32'd0))

endmodule

bind qos_vote_max_aggregator_core qva_checker u_qva_checker (.*);

[tb/sv/tb_qos_vote_max_aggregator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vote aggregator core testbench
// Streams vote, clear and query requests into the core; both sides stall
// at random until only the last requests are left. Each accepted request
// runs through a behavioral copy of the per-class vote tables, and each
// result is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_qos_vote_max_aggregator_core;
    import qva_pkg::*;

    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam logic [2:0] CLASS_LAST    = 3'd7;
    localparam int         POOL_IDS      = 20;
    localparam int         RANDOM_ITEMS  = 1950;
    localparam int         QUIET_TAIL    = 150;
    localparam int         DRAIN_CYCLES  = 2 * VOTE_SLOTS + 8;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  cls;
        logic [31:0] id;
        logic [31:0] val;
    } vote_req_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    vote_req_t   pending_reqs[$];
    vote_req_t   req_in_flight;
    result_t     expected_results[$];
    result_t     seen_result;
    result_t     wanted_result;
    logic [31:0] vote_id_tbl[NUM_CLASSES][VOTE_SLOTS];
    logic [31:0] vote_val_tbl[NUM_CLASSES][VOTE_SLOTS];
    logic [31:0] applied_tbl[NUM_CLASSES];
    logic [31:0] id_pool[NUM_CLASSES][POOL_IDS];
    int          src_gap;
    int          sink_gap;
    int          fail_count;
    bit          stalls_on;

    qos_vote_max_aggregator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int find_slot(logic [2:0] c, logic [31:0] id);
        for (int s = 0; s < VOTE_SLOTS; s++) begin
            if (vote_id_tbl[c][s] == id) return s;
        end
        return -1;
    endfunction

    function automatic result_t apply_vote_op(vote_req_t r);
        result_t     res;
        int          slot;
        logic [31:0] eid;
        logic [31:0] peak;
        logic [31:0] prior;
        bit          modify;
        res = '0;
        res.status = STATUS_OK;
        modify = 1'b0;
        if (r.cls >= NUM_CLASSES) begin
            res.status = STATUS_BAD_CLASS;
            return res;
        end
        case (r.op)
            OP_REQUEST: begin
                eid = (r.id == 32'd0) ? DEFAULT_VOTE_ID : r.id;
                slot = find_slot(r.cls, eid);
                if (slot < 0) slot = find_slot(r.cls, 32'd0);
                if (slot < 0) begin
                    res.status = STATUS_FULL;
                end else begin
                    vote_id_tbl[r.cls][slot] = eid;
                    vote_val_tbl[r.cls][slot] = r.val;
                end
                modify = 1'b1;
            end
            OP_CLEAR: begin
                for (int s = 0; s < VOTE_SLOTS; s++) vote_val_tbl[r.cls][s] = 32'd0;
                modify = 1'b1;
            end
            OP_GET_VOTE, OP_VOTE_ACTIVE: begin
                slot = find_slot(r.cls, r.id);
                if (slot >= 0) begin
                    res.vote_value = vote_val_tbl[r.cls][slot];
                    res.vote_active = (vote_val_tbl[r.cls][slot] != 32'd0);
                end
            end
            default: ;
        endcase
        peak = 32'd0;
        for (int s = 0; s < VOTE_SLOTS; s++) begin
            if (vote_id_tbl[r.cls][s] == 32'd0) break;
            if (vote_val_tbl[r.cls][s] > peak) peak = vote_val_tbl[r.cls][s];
        end
        if (modify) begin
            prior = applied_tbl[r.cls];
            if (prior != peak) begin
                res.target_changed = 1'b1;
                if (r.cls == 3'd0) begin
                    res.power_up = (prior == 32'd0);
                    res.power_down = (prior != 32'd0) && (peak == 32'd0);
                end
                applied_tbl[r.cls] = peak;
            end
        end
        res.class_target = peak;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic add_req(logic [2:0] op, logic [2:0] cls, logic [31:0] id,
                           logic [31:0] val);
        vote_req_t r;
        r.op = op;
        r.cls = cls;
        r.id = id;
        r.val = val;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 32'd0;
        if (r < 50) return 32'($urandom_range(1, 1000));
        if (r < 60) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // driver: predict on accept, then present the next request or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(apply_vote_op(req_in_flight));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else begin
                    req_in_flight = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {req_in_flight.val, req_in_flight.id};
                    s_tuser <= {req_in_flight.cls, req_in_flight.op};
                end
            end
        end
    end

    // monitor: check accepted results and stall the result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_result = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none pending", seen_result.class_target, 0);
                end else begin
                    wanted_result = expected_results.pop_front();
                    if (seen_result.status != wanted_result.status)
                        report_mismatch("status", 32'(seen_result.status),
                                        32'(wanted_result.status));
                    if (seen_result.class_target != wanted_result.class_target)
                        report_mismatch("class_target", seen_result.class_target,
                                        wanted_result.class_target);
                    if (seen_result.vote_value != wanted_result.vote_value)
                        report_mismatch("vote_value", seen_result.vote_value,
                                        wanted_result.vote_value);
                    if (seen_result.vote_active != wanted_result.vote_active)
                        report_mismatch("vote_active", 32'(seen_result.vote_active),
                                        32'(wanted_result.vote_active));
                    if (seen_result.target_changed != wanted_result.target_changed)
                        report_mismatch("target_changed", 32'(seen_result.target_changed),
                                        32'(wanted_result.target_changed));
                    if (seen_result.power_up != wanted_result.power_up)
                        report_mismatch("power_up", 32'(seen_result.power_up),
                                        32'(wanted_result.power_up));
                    if (seen_result.power_down != wanted_result.power_down)
                        report_mismatch("power_down", 32'(seen_result.power_down),
                                        32'(wanted_result.power_down));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) stalls_on <= (pending_reqs.size() > QUIET_TAIL);

    initial begin
        logic [2:0]  op;
        logic [2:0]  cls;
        logic [31:0] id;
        int          r;
        fail_count = 0;
        stalls_on = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            applied_tbl[c] = 32'd0;
            for (int s = 0; s < VOTE_SLOTS; s++) begin
                vote_id_tbl[c][s] = 32'd0;
                vote_val_tbl[c][s] = 32'd0;
            end
            id_pool[c][0] = DEFAULT_VOTE_ID;
            for (int k = 1; k < POOL_IDS; k++) id_pool[c][k] = $urandom_range(1, 32'hFFFF_FFFF);
        end

        add_req(OP_GET_TARGET, 3'd0, 32'd0, 32'd0);
        add_req(OP_GET_VOTE, 3'd0, 32'd0, 32'd0);
        add_req(OP_REQUEST, 3'd0, 32'd0, 32'd100);
        add_req(OP_GET_VOTE, 3'd0, DEFAULT_VOTE_ID, 32'd0);
        add_req(OP_REQUEST, 3'd0, DEFAULT_VOTE_ID, 32'hFFFF_FFFF);
        add_req(OP_REQUEST, 3'd0, DEFAULT_VOTE_ID, 32'hFFFF_FFFF);
        add_req(OP_CLEAR, 3'd0, 32'd0, 32'd0);
        add_req(OP_VOTE_ACTIVE, 3'd0, DEFAULT_VOTE_ID, 32'd0);
        add_req(OP_REQUEST, 3'(NUM_CLASSES), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(OP_RSVD_LAST, CLASS_LAST, 32'd1, 32'd1);
        for (int k = OP_RSVD_FIRST; k <= OP_RSVD_LAST; k++) add_req(3'(k), 3'd1, 32'd0, 32'd0);
        // fill one class, then overflow it
        for (int k = 1; k <= VOTE_SLOTS; k++)
            add_req(OP_REQUEST, 3'(NUM_CLASSES - 1), 32'h8000_0000 | 32'(k), $urandom());
        add_req(OP_REQUEST, 3'(NUM_CLASSES - 1), 32'hFFFF_FFFF, 32'd5);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 6) cls = 3'($urandom_range(NUM_CLASSES, CLASS_LAST));
            else if (r < 36) cls = 3'd0;
            else cls = 3'($urandom_range(0, NUM_CLASSES - 1));
            r = $urandom_range(0, 99);
            if (r < 50) op = OP_REQUEST;
            else if (r < 56) op = OP_CLEAR;
            else if (r < 64) op = OP_GET_TARGET;
            else if (r < 78) op = OP_GET_VOTE;
            else if (r < 94) op = OP_VOTE_ACTIVE;
            else op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            r = $urandom_range(0, 99);
            if (r < 5) id = 32'd0;
            else if (r < 12) id = $urandom();
            else id = id_pool[(cls < NUM_CLASSES) ? cls : 0][$urandom_range(0, POOL_IDS - 1)];
            add_req(op, cls, id, pick_value());
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[qos_vote_max_aggregator_core.f]
+incdir+rtl
rtl/qva_pkg.sv
rtl/qva_ram.sv
rtl/qos_vote_max_aggregator_core.sv
rtl/qva_checker.sv
tb/sv/tb_qos_vote_max_aggregator_core.sv
